// ===== rtl/core/dkq_pkg.sv =====
`timescale 1ns / 1ps
// Package for the DTMF key qualifier: widths, reset values, register codes,
// shared structs and the key-to-ASCII table. No dependencies.
package dkq_pkg;

  localparam int unsigned MagW     = 32;
  localparam int unsigned TickW    = 32;
  localparam int unsigned WindowW  = 16;
  localparam int unsigned CountW   = 5;
  localparam int unsigned QuietW   = 4;
  localparam int unsigned KeyW     = 4;
  localparam int unsigned CharW    = 7;
  localparam int unsigned NumTones = 4;
  localparam int unsigned InDataW  = 9 * MagW;
  localparam int unsigned OutDataW = 16;
  localparam int unsigned CfgIdxW  = 2;
  localparam int unsigned CfgDataW = 32;

  localparam logic [MagW-1:0]    ThresholdRst = 32'd4000000;
  localparam logic [WindowW-1:0] WindowRst    = 16'd1500;
  localparam logic [CountW-1:0]  ConfirmRst   = 5'd5;
  localparam logic [QuietW-1:0]  QuietLimRst  = 4'd2;
  localparam logic [CountW-1:0]  RepeatRst    = 5'd10;
  localparam logic [CountW-1:0]  RepeatMax    = 5'd31;
  localparam logic [QuietW-1:0]  QuietMax     = 4'd15;

  typedef enum logic [CfgIdxW-1:0] {
    REG_THRESHOLD = 2'd0,
    REG_WINDOW    = 2'd1,
    REG_CONFIRM   = 2'd2,
    REG_QUIET_LIM = 2'd3
  } cfg_reg_e;

  typedef struct packed {
    logic [MagW-1:0]    threshold;
    logic [WindowW-1:0] window;
    logic [CountW-1:0]  confirm;
    logic [QuietW-1:0]  quiet_lim;
  } cfg_t;

  typedef struct packed {
    logic            row_found;
    logic            col_found;
    logic [KeyW-1:0] key;
  } det_t;

  typedef struct packed {
    logic             key_valid;
    logic [KeyW-1:0]  key_index;
    logic [CharW-1:0] key_char;
  } res_t;

  // Keypad layout, row-major: 1 2 3 A / 4 5 6 B / 7 8 9 C / * 0 # D
  function automatic logic [CharW-1:0] key_ascii(input logic [KeyW-1:0] k);
    logic [CharW-1:0] c;
    case (k)
      4'd0:    c = 7'h31;
      4'd1:    c = 7'h32;
      4'd2:    c = 7'h33;
      4'd3:    c = 7'h41;
      4'd4:    c = 7'h34;
      4'd5:    c = 7'h35;
      4'd6:    c = 7'h36;
      4'd7:    c = 7'h42;
      4'd8:    c = 7'h37;
      4'd9:    c = 7'h38;
      4'd10:   c = 7'h39;
      4'd11:   c = 7'h43;
      4'd12:   c = 7'h2A;
      4'd13:   c = 7'h30;
      4'd14:   c = 7'h23;
      default: c = 7'h44;
    endcase
    return c;
  endfunction

endpackage

// ===== rtl/core/dkq_decode.sv =====
`timescale 1ns / 1ps
// Tone decode: finds the lowest row and column tone above threshold and
// forms the key index. Depends on dkq_pkg.
module dkq_decode (
  input  logic [dkq_pkg::InDataW-1:0] item_i,
  input  logic [dkq_pkg::MagW-1:0]    threshold_i,
  output dkq_pkg::det_t               det_o
);

  logic [dkq_pkg::NumTones-1:0] row_hit;
  logic [dkq_pkg::NumTones-1:0] col_hit;
  logic [1:0]                   row_idx;
  logic [1:0]                   col_idx;

  always_comb begin
    for (int i = 0; i < dkq_pkg::NumTones; i++) begin
      row_hit[i] = item_i[i*dkq_pkg::MagW +: dkq_pkg::MagW] > threshold_i;
      col_hit[i] = item_i[(i+dkq_pkg::NumTones)*dkq_pkg::MagW +: dkq_pkg::MagW]
                   > threshold_i;
    end
  end

  // priority: lowest index wins
  always_comb begin
    row_idx = 2'd3;
    col_idx = 2'd3;
    for (int i = dkq_pkg::NumTones - 1; i >= 0; i--) begin
      if (row_hit[i]) row_idx = 2'(i);
      if (col_hit[i]) col_idx = 2'(i);
    end
  end

  assign det_o.row_found = |row_hit;
  assign det_o.col_found = |col_hit;
  assign det_o.key       = {row_idx, col_idx};

endmodule

// ===== rtl/core/dkq_track.sv =====
`timescale 1ns / 1ps
// Key tracking state: repeat/quiet counters, previous key and clear tick.
// Produces the result for the item consumed this cycle. Depends on dkq_pkg.
module dkq_track (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      en_i,
  input  dkq_pkg::det_t             det_i,
  input  logic [dkq_pkg::TickW-1:0] now_tick_i,
  input  dkq_pkg::cfg_t             cfg_i,
  output dkq_pkg::res_t             res_o
);

  logic                       present_q, present_d;
  logic [dkq_pkg::KeyW-1:0]   prev_key_q, prev_key_d;
  logic [dkq_pkg::CountW-1:0] repeat_q, repeat_d;
  logic [dkq_pkg::QuietW-1:0] quiet_q, quiet_d;
  logic [dkq_pkg::TickW-1:0]  clear_tick_q, clear_tick_d;

  logic                       hit;
  logic [dkq_pkg::CountW-1:0] repeat_inc;
  logic                       report;
  logic [dkq_pkg::TickW-1:0]  delta;

  assign repeat_inc = repeat_q + 1'b1;
  assign hit = present_q && (prev_key_q == det_i.key) && (repeat_q < dkq_pkg::RepeatMax);
  assign delta = now_tick_i - clear_tick_q;

  always_comb begin
    present_d    = present_q;
    prev_key_d   = prev_key_q;
    repeat_d     = repeat_q;
    quiet_d      = quiet_q;
    clear_tick_d = clear_tick_q;
    report       = 1'b0;
    if (det_i.row_found) begin
      // row without column leaves everything alone
      if (det_i.col_found) begin
        if (hit) begin
          repeat_d = repeat_inc;
          if (repeat_inc == cfg_i.confirm) begin
            report  = 1'b1;
            quiet_d = '0;
          end
        end
        prev_key_d = det_i.key;
        present_d  = 1'b1;
      end
    end else if (quiet_q > cfg_i.quiet_lim) begin
      // quiet run complete: forget key, re-arm if close to last clear
      if (delta < {{(dkq_pkg::TickW-dkq_pkg::WindowW){1'b0}}, cfg_i.window}) begin
        repeat_d = '0;
      end
      quiet_d      = '0;
      clear_tick_d = now_tick_i;
      present_d    = 1'b0;
    end else if (quiet_q < dkq_pkg::QuietMax) begin
      quiet_d = quiet_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      present_q    <= 1'b0;
      prev_key_q   <= '0;
      repeat_q     <= dkq_pkg::RepeatRst;
      quiet_q      <= '0;
      clear_tick_q <= '0;
    end else if (en_i) begin
      present_q    <= present_d;
      prev_key_q   <= prev_key_d;
      repeat_q     <= repeat_d;
      quiet_q      <= quiet_d;
      clear_tick_q <= clear_tick_d;
    end
  end

  assign res_o.key_valid = report;
  assign res_o.key_index = report ? det_i.key : '0;
  assign res_o.key_char  = report ? dkq_pkg::key_ascii(det_i.key) : '0;

endmodule

// ===== rtl/core/dtmf_key_qualifier_unit.sv =====
`timescale 1ns / 1ps
// Top level of the DTMF key qualifier: config registers, input register,
// result register. Depends on dkq_pkg, dkq_decode, dkq_track.
//
//  channel   direction  payload
//  s_axis    in         tdata: row_mag_0..3, col_mag_0..3, now_tick (288 b)
//  m_axis    out        tuser: key_valid; tdata: key_index, key_char
//  cfg       in         cfg_index_i selects register, cfg_data_i value
//
// An input item is held in the input register, then passes through decode/track
// logic into the result register. One item per cycle is sustained while m_axis
// is ready. Reset clears control state, loads register defaults and resets the
// tracking state, with the repeat count set to RepeatRst.
// A stalled m_axis holds the result and the input register backs up behind it.
module dtmf_key_qualifier_unit (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // row_mag_0..3 [127:0], col_mag_0..3 [255:128], now_tick [287:256]
  input  logic [dkq_pkg::InDataW-1:0]   s_axis_tdata,
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  // key_index [3:0], key_char [10:4], zero fill [15:11]
  output logic [dkq_pkg::OutDataW-1:0]  m_axis_tdata,
  // key_valid [0]
  output logic                          m_axis_tuser,
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [dkq_pkg::CfgIdxW-1:0]   cfg_index_i,
  input  logic [dkq_pkg::CfgDataW-1:0]  cfg_data_i
);

  dkq_pkg::cfg_t                 cfg_q;
  logic                          in_vld_q, in_vld_d;
  logic [dkq_pkg::InDataW-1:0]   in_data_q;
  logic                          out_vld_q, out_vld_d;
  dkq_pkg::res_t                 out_res_q;
  logic                          s_accept;
  logic                          advance;
  dkq_pkg::det_t                 det;
  dkq_pkg::res_t                 res;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.threshold <= dkq_pkg::ThresholdRst;
      cfg_q.window    <= dkq_pkg::WindowRst;
      cfg_q.confirm   <= dkq_pkg::ConfirmRst;
      cfg_q.quiet_lim <= dkq_pkg::QuietLimRst;
    end else if (cfg_valid_i) begin
      unique case (dkq_pkg::cfg_reg_e'(cfg_index_i))
        dkq_pkg::REG_THRESHOLD: cfg_q.threshold <= cfg_data_i;
        dkq_pkg::REG_WINDOW:    cfg_q.window    <= cfg_data_i[dkq_pkg::WindowW-1:0];
        dkq_pkg::REG_CONFIRM:   cfg_q.confirm   <= cfg_data_i[dkq_pkg::CountW-1:0];
        dkq_pkg::REG_QUIET_LIM: cfg_q.quiet_lim <= cfg_data_i[dkq_pkg::QuietW-1:0];
      endcase
    end
  end

  assign advance       = in_vld_q && (!out_vld_q || m_axis_tready);
  assign s_axis_tready = !in_vld_q || advance;
  assign s_accept      = s_axis_tvalid && s_axis_tready;

  always_comb begin
    in_vld_d = in_vld_q;
    if (s_accept)     in_vld_d = 1'b1;
    else if (advance) in_vld_d = 1'b0;
    out_vld_d = out_vld_q;
    if (advance)            out_vld_d = 1'b1;
    else if (m_axis_tready) out_vld_d = 1'b0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      in_vld_q  <= in_vld_d;
      out_vld_q <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_accept) in_data_q <= s_axis_tdata;
    if (advance)  out_res_q <= res;
  end

  dkq_decode u_decode (
    .item_i      (in_data_q),
    .threshold_i (cfg_q.threshold),
    .det_o       (det)
  );

  dkq_track u_track (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .en_i       (advance),
    .det_i      (det),
    .now_tick_i (in_data_q[8*dkq_pkg::MagW +: dkq_pkg::TickW]),
    .cfg_i      (cfg_q),
    .res_o      (res)
  );

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tuser  = out_res_q.key_valid;
  assign m_axis_tdata  = {{(dkq_pkg::OutDataW-dkq_pkg::KeyW-dkq_pkg::CharW){1'b0}},
                          out_res_q.key_char, out_res_q.key_index};

`ifndef SYNTHESIS
  // a reported key always carries a printable character
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser |-> m_axis_tdata[10:4] != 7'd0)
    else $error("reported key without character");

  // no report means an all-zero payload
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tuser |-> m_axis_tdata == '0)
    else $error("non-report carries key data");

  // a held input item is not overwritten
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_vld_q && !advance |=> in_vld_q && $stable(in_data_q))
    else $error("input register lost an item");

  // a held result is not overwritten while stalled
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_vld_q && !m_axis_tready |=> out_vld_q && $stable(out_res_q))
    else $error("result register overwritten under stall");
`endif

endmodule

// ===== bench/dtmf_key_checker.sv =====
`timescale 1ns / 1ps
// Checker for the DTMF key qualifier: watches the config, input and result channels,
// tracks key qualification state on its own and compares every result transaction.
// Depends on dkq_pkg.
module dtmf_key_checker (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic [dkq_pkg::InDataW-1:0]  s_tdata_i,
  input  logic                         s_tvalid_i,
  input  logic                         s_tready_i,
  input  logic [dkq_pkg::OutDataW-1:0] m_tdata_i,
  input  logic                         m_tuser_i,
  input  logic                         m_tvalid_i,
  input  logic                         m_tready_i,
  input  logic                         cfg_valid_i,
  input  logic                         cfg_ready_i,
  input  logic [dkq_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  logic [dkq_pkg::CfgDataW-1:0] cfg_data_i,
  output int                           fail_cnt_o,
  output int                           pending_o,
  output int                           reports_o
);

  localparam logic [8*16-1:0] KeyGlyphs = "123A456B789C*0#D";

  dkq_pkg::cfg_t               cfg_q;
  logic                        key_present_q;
  logic [dkq_pkg::KeyW-1:0]    key_q;
  logic [dkq_pkg::CountW-1:0]  press_cnt_q;
  logic [dkq_pkg::QuietW-1:0]  quiet_cnt_q;
  logic [dkq_pkg::TickW-1:0]   clear_tick_q;

  dkq_pkg::res_t key_results_q[$];
  int            fails;
  int            reports;

  assign fail_cnt_o = fails;
  assign reports_o  = reports;

  // Lowest tone index strictly above the threshold, 4 when none.
  function automatic logic [2:0] first_loud(input logic [4*dkq_pkg::MagW-1:0] mags);
    for (int i = 0; i < dkq_pkg::NumTones; i++) begin
      if (mags[i*dkq_pkg::MagW +: dkq_pkg::MagW] > cfg_q.threshold) return 3'(i);
    end
    return 3'd4;
  endfunction

  function automatic logic [dkq_pkg::CharW-1:0] key_glyph(
      input logic [dkq_pkg::KeyW-1:0] k);
    return KeyGlyphs[8*(15 - int'(k)) +: dkq_pkg::CharW];
  endfunction

  task automatic qualify_block(input logic [dkq_pkg::InDataW-1:0] blk,
                               output dkq_pkg::res_t r);
    logic [2:0]                row;
    logic [2:0]                col;
    logic [dkq_pkg::KeyW-1:0]  k;
    logic [dkq_pkg::TickW-1:0] now;
    logic [dkq_pkg::TickW-1:0] since_clear;
    row = first_loud(blk[4*dkq_pkg::MagW-1:0]);
    col = first_loud(blk[8*dkq_pkg::MagW-1:4*dkq_pkg::MagW]);
    now = blk[8*dkq_pkg::MagW +: dkq_pkg::TickW];
    r   = '0;
    if (row != 3'd4) begin
      // a row with no column leaves everything untouched
      if (col != 3'd4) begin
        k = {row[1:0], col[1:0]};
        if (key_present_q && key_q == k && press_cnt_q < dkq_pkg::RepeatMax) begin
          press_cnt_q = press_cnt_q + 1'b1;
          if (press_cnt_q == cfg_q.confirm) begin
            quiet_cnt_q = '0;
            r.key_valid = 1'b1;
            r.key_index = k;
            r.key_char  = key_glyph(k);
          end
        end
        key_q         = k;
        key_present_q = 1'b1;
      end
    end else begin
      since_clear = now - clear_tick_q;
      if (quiet_cnt_q > cfg_q.quiet_lim) begin
        if (since_clear < {{(dkq_pkg::TickW-dkq_pkg::WindowW){1'b0}}, cfg_q.window}) begin
          press_cnt_q = '0;
        end
        quiet_cnt_q   = '0;
        clear_tick_q  = now;
        key_present_q = 1'b0;
      end else if (quiet_cnt_q < dkq_pkg::QuietMax) begin
        quiet_cnt_q = quiet_cnt_q + 1'b1;
      end
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    dkq_pkg::res_t want;
    dkq_pkg::res_t got;
    if (!rst_ni) begin
      cfg_q         = '{threshold: dkq_pkg::ThresholdRst, window: dkq_pkg::WindowRst,
                        confirm: dkq_pkg::ConfirmRst, quiet_lim: dkq_pkg::QuietLimRst};
      key_present_q = 1'b0;
      key_q         = '0;
      press_cnt_q   = dkq_pkg::RepeatRst;
      quiet_cnt_q   = '0;
      clear_tick_q  = '0;
      key_results_q.delete();
      fails         = 0;
      reports       = 0;
      pending_o    <= 0;
    end else begin
      if (cfg_valid_i && cfg_ready_i) begin
        case (dkq_pkg::cfg_reg_e'(cfg_index_i))
          dkq_pkg::REG_THRESHOLD: cfg_q.threshold = cfg_data_i[dkq_pkg::MagW-1:0];
          dkq_pkg::REG_WINDOW:    cfg_q.window    = cfg_data_i[dkq_pkg::WindowW-1:0];
          dkq_pkg::REG_CONFIRM:   cfg_q.confirm   = cfg_data_i[dkq_pkg::CountW-1:0];
          dkq_pkg::REG_QUIET_LIM: cfg_q.quiet_lim = cfg_data_i[dkq_pkg::QuietW-1:0];
          default: ;
        endcase
      end
      if (s_tvalid_i && s_tready_i) begin
        qualify_block(s_tdata_i, want);
        key_results_q.push_back(want);
      end
      if (m_tvalid_i && m_tready_i) begin
        got.key_valid = m_tuser_i;
        got.key_index = m_tdata_i[dkq_pkg::KeyW-1:0];
        got.key_char  = m_tdata_i[dkq_pkg::KeyW +: dkq_pkg::CharW];
        if (key_results_q.size() == 0) begin
          $error("result with nothing pending: key_valid %0b key_index %0d key_char %h",
                 got.key_valid, got.key_index, got.key_char);
          fails++;
        end else begin
          want = key_results_q.pop_front();
          if (got.key_valid !== want.key_valid) begin
            $error("key_valid: expected %0b, got %0b", want.key_valid, got.key_valid);
            fails++;
          end
          if (got.key_index !== want.key_index) begin
            $error("key_index: expected %0d, got %0d", want.key_index, got.key_index);
            fails++;
          end
          if (got.key_char !== want.key_char) begin
            $error("key_char: expected %h, got %h", want.key_char, got.key_char);
            fails++;
          end
          if (want.key_valid) reports++;
        end
      end
      pending_o <= key_results_q.size();
    end
  end

endmodule

// ===== bench/tb_dtmf_key_qualifier_unit.sv =====
`timescale 1ns / 1ps
// Testbench top for dtmf_key_qualifier_unit: clock, reset, config writes, tone-block
// stimulus and result back-pressure. Depends on dkq_pkg, dtmf_key_qualifier_unit and dtmf_key_checker.
module tb_dtmf_key_qualifier_unit;

  localparam int HoldCycles = 300;
  localparam int StallLimit = 3000;

  logic                         clk_i = 1'b0;
  logic                         rst_ni;
  logic [dkq_pkg::InDataW-1:0]  s_axis_tdata;
  logic                         s_axis_tvalid;
  logic                         s_axis_tready;
  logic [dkq_pkg::OutDataW-1:0] m_axis_tdata;
  logic                         m_axis_tuser;
  logic                         m_axis_tvalid;
  logic                         m_axis_tready;
  logic                         cfg_valid_i;
  logic                         cfg_ready_o;
  logic [dkq_pkg::CfgIdxW-1:0]  cfg_index_i;
  logic [dkq_pkg::CfgDataW-1:0] cfg_data_i;

  int fail_cnt;
  int pending_cnt;
  int keys_reported;

  // stimulus-side copy of the settings, used only to shape the traffic
  logic [dkq_pkg::MagW-1:0]    cur_thr  = dkq_pkg::ThresholdRst;
  logic [dkq_pkg::WindowW-1:0] cur_win  = dkq_pkg::WindowRst;
  logic [dkq_pkg::CountW-1:0]  cur_conf = dkq_pkg::ConfirmRst;
  logic [dkq_pkg::QuietW-1:0]  cur_qlim = dkq_pkg::QuietLimRst;
  logic [dkq_pkg::TickW-1:0]   cur_tick = '0;

  int blocks_sent = 0;
  int reg_writes  = 0;
  int idle_cycles = 0;
  bit tx_calm     = 1'b0;
  bit all_calm    = 1'b0;
  bit rx_hold_req = 1'b0;

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  dtmf_key_qualifier_unit dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i)
  );

  dtmf_key_checker u_checker (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .s_tdata_i   (s_axis_tdata),
    .s_tvalid_i  (s_axis_tvalid),
    .s_tready_i  (s_axis_tready),
    .m_tdata_i   (m_axis_tdata),
    .m_tuser_i   (m_axis_tuser),
    .m_tvalid_i  (m_axis_tvalid),
    .m_tready_i  (m_axis_tready),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_i (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .fail_cnt_o  (fail_cnt),
    .pending_o   (pending_cnt),
    .reports_o   (keys_reported)
  );

  // Watchdog: any transaction on any channel restarts the count.
  always @(posedge clk_i) begin
    if (!rst_ni || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
        (cfg_valid_i && cfg_ready_o)) begin
      idle_cycles <= 0;
    end else if (idle_cycles == StallLimit) begin
      $display("FAILURE");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // Result sink: random stall bursts, calm stretches, one long hold-off on request.
  initial begin : result_sink
    int gap_left;
    int hold_left;
    int calm_left;
    gap_left  = 0;
    hold_left = 0;
    calm_left = 0;
    m_axis_tready <= 1'b0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (rx_hold_req) begin
        rx_hold_req = 1'b0;
        hold_left   = HoldCycles;
      end
      if (hold_left > 0) begin
        hold_left--;
        m_axis_tready <= 1'b0;
      end else if (gap_left > 0) begin
        gap_left--;
        m_axis_tready <= 1'b0;
      end else if (!all_calm && calm_left == 0 && $urandom_range(0, 5) == 0) begin
        gap_left = $urandom_range(1, 9) - 1;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= 1'b1;
      end
      if (calm_left > 0) calm_left--;
      else if ($urandom_range(0, 99) == 0) calm_left = $urandom_range(30, 120);
    end
  end

  function automatic logic [dkq_pkg::MagW-1:0] loud_mag(input bit at_bound);
    if (cur_thr == '1) return '1;  // nothing can be louder
    if (at_bound) return cur_thr + 1'b1;
    case ($urandom_range(0, 3))
      0:       return cur_thr + 1'b1;
      1:       return '1;
      default: return $urandom_range(32'hFFFF_FFFF, cur_thr + 1'b1);
    endcase
  endfunction

  function automatic logic [dkq_pkg::MagW-1:0] faint_mag(input bit at_bound);
    if (at_bound) return cur_thr;
    case ($urandom_range(0, 3))
      0:       return cur_thr;
      1:       return '0;
      default: return $urandom_range(cur_thr, 0);
    endcase
  endfunction

  // tdata: row_mag_0..3, col_mag_0..3, now_tick from the low bits up
  function automatic logic [dkq_pkg::InDataW-1:0] make_block(
      input logic [3:0] rows,
      input logic [3:0] cols,
      input logic [dkq_pkg::TickW-1:0] tick,
      input bit at_bound);
    logic [dkq_pkg::InDataW-1:0] blk;
    for (int i = 0; i < dkq_pkg::NumTones; i++) begin
      blk[i*dkq_pkg::MagW +: dkq_pkg::MagW] =
          rows[i] ? loud_mag(at_bound) : faint_mag(at_bound);
      blk[(4+i)*dkq_pkg::MagW +: dkq_pkg::MagW] =
          cols[i] ? loud_mag(at_bound) : faint_mag(at_bound);
    end
    blk[8*dkq_pkg::MagW +: dkq_pkg::TickW] = tick;
    return blk;
  endfunction

  // The wanted tone, sometimes with other loud tones of higher index beside it.
  function automatic logic [3:0] tone_mask(input int idx);
    logic [3:0] m;
    m = 4'b0001 << idx;
    if ($urandom_range(0, 2) == 0) m |= 4'($urandom_range(0, 15)) & (4'b1110 << idx);
    return m;
  endfunction

  function automatic logic [dkq_pkg::TickW-1:0] next_tick();
    case ($urandom_range(0, 19))
      0:       cur_tick = $urandom();
      1, 2, 3: cur_tick += $urandom_range(int'(cur_win), int'(cur_win) + 100);
      default: cur_tick += $urandom_range(0, int'(cur_win >> 3) + 2);
    endcase
    return cur_tick;
  endfunction

  task automatic send_block(input logic [dkq_pkg::InDataW-1:0] blk);
    if (!tx_calm && !all_calm && $urandom_range(0, 4) == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 9)) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= blk;
    do @(posedge clk_i); while (!s_axis_tready);
    blocks_sent++;
  endtask

  task automatic send_key(input int k);
    send_block(make_block(tone_mask(k / 4), tone_mask(k % 4), next_tick(), 1'b0));
  endtask

  task automatic send_quiet();
    send_block(make_block(4'b0000, 4'($urandom_range(0, 15)), next_tick(), 1'b0));
  endtask

  task automatic wait_idle();
    s_axis_tvalid <= 1'b0;
    do @(posedge clk_i); while (pending_cnt != 0);
  endtask

  // Leaves cfg_valid_i high so back-to-back writes go out with no gap between them.
  task automatic write_reg(input dkq_pkg::cfg_reg_e idx,
                           input logic [dkq_pkg::CfgDataW-1:0] val);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    reg_writes++;
  endtask

  // Upper data bits beyond each register's width carry junk.
  task automatic apply_settings(input logic [dkq_pkg::MagW-1:0]    thr,
                                input logic [dkq_pkg::WindowW-1:0] win,
                                input logic [dkq_pkg::CountW-1:0]  conf,
                                input logic [dkq_pkg::QuietW-1:0]  qlim);
    wait_idle();
    write_reg(dkq_pkg::REG_THRESHOLD, thr);
    write_reg(dkq_pkg::REG_WINDOW, {16'($urandom()), win});
    write_reg(dkq_pkg::REG_CONFIRM, {27'($urandom()), conf});
    write_reg(dkq_pkg::REG_QUIET_LIM, {28'($urandom()), qlim});
    cfg_valid_i <= 1'b0;
    cur_thr  = thr;
    cur_win  = win;
    cur_conf = conf;
    cur_qlim = qlim;
  endtask

  // Mostly whole key presses followed by quiet runs; the rest is stray tone mixes
  // and rows without a column.
  task automatic run_traffic(input int n);
    int stop_at;
    int k;
    int len;
    stop_at = blocks_sent + n;
    while (blocks_sent < stop_at) begin
      if ($urandom_range(0, 5) == 0) tx_calm = !tx_calm;
      case ($urandom_range(0, 9))
        0: send_block(make_block(4'($urandom_range(0, 15)), 4'($urandom_range(0, 15)),
                                 next_tick(), 1'b0));
        1: begin
          send_block(make_block(4'($urandom_range(1, 15)), 4'b0000, next_tick(), 1'b0));
          stop_at++;
        end
        default: begin
          k   = $urandom_range(0, 15);
          len = $urandom_range(1, int'(cur_conf) + 3);
          repeat (len) send_key(k);
          len = $urandom_range(0, int'(cur_qlim) + 3);
          repeat (len) send_quiet();
        end
      endcase
    end
  endtask

  initial begin
    rst_ni        <= 1'b0;
    s_axis_tvalid <= 1'b0;
    s_axis_tdata  <= '0;
    cfg_valid_i   <= 1'b0;
    cfg_index_i   <= dkq_pkg::REG_THRESHOLD;
    cfg_data_i    <= '0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed, under reset settings. Quiet run completes near tick zero and re-arms.
    send_block('0);
    send_block('1);
    send_block(make_block(4'b0000, 4'b0000, 32'd10, 1'b1));
    send_block(make_block(4'b0000, 4'b0000, 32'd20, 1'b1));
    send_block(make_block(4'b0000, 4'b0000, 32'd30, 1'b1));
    // key 5 at one step above threshold: confirmed on the sixth, silent on the seventh
    repeat (7) send_block(make_block(4'b0010, 4'b0010, 32'd40, 1'b1));
    send_block(make_block(4'b0100, 4'b0000, 32'd50, 1'b1));
    send_block(make_block(4'b1100, 4'b1111, 32'd60, 1'b0));
    send_block(make_block(4'b0000, 4'b1111, 32'd70, 1'b0));
    cur_tick = 32'd70;

    apply_settings(32'd1000, 16'd2000, 5'd3, 4'd1);
    run_traffic(180);
    apply_settings(32'd0, 16'hFFFF, 5'd1, 4'd0);
    run_traffic(120);
    // nothing can exceed the top threshold: every block is quiet
    apply_settings(32'hFFFF_FFFF, 16'hFFFF, 5'($urandom_range(0, 31)),
                   4'($urandom_range(0, 3)));
    run_traffic(20);
    // quiet runs never complete; long holds reach the saturating count
    apply_settings(32'hFFFF_FFFE, 16'hFFFF, 5'd31, 4'd15);
    run_traffic(80);
    apply_settings($urandom(), 16'd0, 5'd0, 4'd14);
    run_traffic(60);
    apply_settings($urandom_range(0, 32'h0010_0000), 16'd300, 5'd2, 4'd2);
    run_traffic(80);

    // sink holds off while keys keep coming, then the source drains fully
    wait_idle();
    tx_calm     = 1'b1;
    rx_hold_req = 1'b1;
    repeat (25) send_key($urandom_range(0, 15));
    wait_idle();
    tx_calm = 1'b0;
    run_traffic(45);

    apply_settings($urandom_range(0, 32'h0000_FFFF), 16'($urandom()),
                   5'($urandom_range(1, 6)), 4'($urandom_range(0, 4)));
    all_calm = 1'b1;
    run_traffic(80);

    wait_idle();
    repeat (4) @(posedge clk_i);
    $display("Run: %0d tone blocks under 8 register settings (%0d writes), %0d keys reported.",
             blocks_sent, reg_writes, keys_reported);
    if (fail_cnt == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/core/dkq_pkg.sv
rtl/core/dkq_decode.sv
rtl/core/dkq_track.sv
rtl/core/dtmf_key_qualifier_unit.sv
bench/dtmf_key_checker.sv
bench/tb_dtmf_key_qualifier_unit.sv
